// ===== rtl/hpes_pkg.sv =====
package hpes_pkg;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  localparam logic [2:0] K_ADD  = 3'd0;
  localparam logic [2:0] K_SUB  = 3'd1;
  localparam logic [2:0] K_MUL  = 3'd2;
  localparam logic [2:0] K_SQRT = 3'd3;
  localparam logic [2:0] K_EXP  = 3'd4;

  localparam int NSRC = 19;
  localparam logic [4:0] SRC_Z1    = 5'd0;
  localparam logic [4:0] SRC_Z2    = 5'd1;
  localparam logic [4:0] SRC_R     = 5'd2;
  localparam logic [4:0] SRC_KAPPA = 5'd3;
  localparam logic [4:0] SRC_THETA = 5'd4;
  localparam logic [4:0] SRC_SIGMA = 5'd5;
  localparam logic [4:0] SRC_RHO   = 5'd6;
  localparam logic [4:0] SRC_DT    = 5'd7;
  localparam logic [4:0] SRC_ONE   = 5'd8;
  localparam logic [4:0] SRC_VP    = 5'd9;
  localparam logic [4:0] SRC_VPH   = 5'd10;
  localparam logic [4:0] SRC_PRICE = 5'd11;
  localparam logic [4:0] SRC_PV    = 5'd12;
  localparam logic [4:0] SRC_T0    = 5'd13;
  localparam logic [4:0] SRC_T1    = 5'd14;
  localparam logic [4:0] SRC_T2    = 5'd15;
  localparam logic [4:0] SRC_T3    = 5'd16;
  localparam logic [4:0] SRC_T4    = 5'd17;
  localparam logic [4:0] SRC_T5    = 5'd18;

  localparam logic [2:0] D_T0    = 3'd0;
  localparam logic [2:0] D_T1    = 3'd1;
  localparam logic [2:0] D_T2    = 3'd2;
  localparam logic [2:0] D_T3    = 3'd3;
  localparam logic [2:0] D_T4    = 3'd4;
  localparam logic [2:0] D_T5    = 3'd5;
  localparam logic [2:0] D_PRICE = 3'd6;
  localparam logic [2:0] D_PV    = 3'd7;

  localparam logic [2:0] REG_S0    = 3'd0;
  localparam logic [2:0] REG_V0    = 3'd1;
  localparam logic [2:0] REG_R     = 3'd2;
  localparam logic [2:0] REG_KAPPA = 3'd3;
  localparam logic [2:0] REG_THETA = 3'd4;
  localparam logic [2:0] REG_SIGMA = 3'd5;
  localparam logic [2:0] REG_RHO   = 3'd6;
  localparam logic [2:0] REG_DT    = 3'd7;

  localparam logic [4:0]  LAST_PC  = 5'd22;
  localparam logic [4:0]  TAYLOR_N = 5'd24;
  localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AB;
  localparam logic [63:0] ONE_Q62  = 64'h4000000000000000;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] a;
    logic [4:0] b;
    logic [2:0] dst;
  } uop_t;

  function automatic uop_t prog(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{K_SQRT, SRC_DT,    SRC_DT,  D_T0};
      5'd1:  u = '{K_MUL,  SRC_RHO,   SRC_RHO, D_T1};
      5'd2:  u = '{K_SUB,  SRC_ONE,   SRC_T1,  D_T1};
      5'd3:  u = '{K_SQRT, SRC_T1,    SRC_T1,  D_T1};
      5'd4:  u = '{K_MUL,  SRC_T1,    SRC_Z2,  D_T1};
      5'd5:  u = '{K_MUL,  SRC_RHO,   SRC_Z1,  D_T2};
      5'd6:  u = '{K_ADD,  SRC_T2,    SRC_T1,  D_T2};
      5'd7:  u = '{K_SQRT, SRC_VP,    SRC_VP,  D_T3};
      5'd8:  u = '{K_SUB,  SRC_R,     SRC_VPH, D_T4};
      5'd9:  u = '{K_MUL,  SRC_T4,    SRC_DT,  D_T4};
      5'd10: u = '{K_MUL,  SRC_T3,    SRC_T0,  D_T5};
      5'd11: u = '{K_MUL,  SRC_T5,    SRC_Z1,  D_T5};
      5'd12: u = '{K_ADD,  SRC_T4,    SRC_T5,  D_T4};
      5'd13: u = '{K_EXP,  SRC_T4,    SRC_T4,  D_T4};
      5'd14: u = '{K_MUL,  SRC_PRICE, SRC_T4,  D_PRICE};
      5'd15: u = '{K_SUB,  SRC_THETA, SRC_VP,  D_T4};
      5'd16: u = '{K_MUL,  SRC_KAPPA, SRC_T4,  D_T4};
      5'd17: u = '{K_MUL,  SRC_T4,    SRC_DT,  D_T4};
      5'd18: u = '{K_MUL,  SRC_SIGMA, SRC_T3,  D_T5};
      5'd19: u = '{K_MUL,  SRC_T5,    SRC_T0,  D_T5};
      5'd20: u = '{K_MUL,  SRC_T5,    SRC_T2,  D_T5};
      5'd21: u = '{K_ADD,  SRC_PV,    SRC_T4,  D_T4};
      5'd22: u = '{K_ADD,  SRC_T4,    SRC_T5,  D_PV};
      default: u = '{K_ADD, SRC_T4,   SRC_T5,  D_T4};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/hpes_mul.sv =====
module hpes_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  hpes_pkg::mul_req_t req,
  output hpes_pkg::mul_rsp_t rsp
);
  import hpes_pkg::*;

  localparam logic [2:0] NPP = 3'd4;

  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   sh_r, sh_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         ppv_r, ppv_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  ah, bh;

  assign ah = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    ppv_nxt  = ppv_r;
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      cnt_nxt  = '0;
      ppv_nxt  = 1'b0;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != NPP) begin
        pp_nxt  = ah * bh;
        sh_nxt  = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
        ppv_nxt = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
      end else begin
        ppv_nxt = 1'b0;
      end
      if (ppv_r) begin
        acc_nxt = acc_r + (128'(pp_r) << {sh_r, 5'd0});
      end
      if (ppv_r && cnt_r == NPP) begin
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ppv_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ppv_r  <= ppv_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/heston_path_euler_step.sv =====
// channel  dir  tdata (low bit up)                          side
// in_      in   shock_one[35:0], shock_two[71:36]           tuser=first_step, tlast=last_step
// out_     out  terminal_price[46:0], terminal_variance[94:47], pad  tuser=overflow
// cfg_     in   cfg_wdata at register cfg_index             cfg_we
//
// One item runs 23 micro-ops on a shared 32x32 multiplier, a one-bit-per-cycle
// square root and a Taylor exponential with 24 terms of one multiply plus a
// divide each, with most of an item's time spent in the exponential.
// Synchronous reset clears control and path state and reloads register defaults.
// in_tready is high only when idle; a waiting result holds in the output
// register, and the next item stalls at its end only if that result is still held.
module heston_path_euler_step #(
  parameter int FRAC_BITS  = 32,
  parameter int WORD_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // shock_one, shock_two
  input  logic        in_tuser,   // first_step
  input  logic        in_tlast,   // last_step
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // terminal_price, terminal_variance, zero pad
  output logic        out_tuser,  // overflow
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [46:0] cfg_wdata
);
  import hpes_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int NQ  = (W + FB + 1) / 2;
  localparam int RWE = 2 * NQ;
  localparam int SCW = $clog2(NQ);
  localparam int XRW = FB + 8;
  localparam int CW  = ((W > FB + 8) ? W : FB + 8) + 2;

  typedef logic signed [W-1:0] word_t;

  localparam logic signed [64:0] WMAX65 = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMIN65 = -WMAX65 - 65'sd1;
  localparam logic [63:0]  WMAX64 = WMAX65[63:0];
  localparam word_t        WMAX   = WMAX65[W-1:0];
  localparam word_t        WMIN   = WMIN65[W-1:0];
  localparam word_t        ONE_W  = (FB <= W - 2) ? (W'(1) << FB) : WMAX;
  localparam logic [127:0] LIMP   = 128'(WMAX64);
  localparam logic [127:0] LIMN   = 128'(WMAX64) + 128'd1;
  localparam logic signed [CW-1:0] XLIM = CW'(64) <<< FB;
  localparam logic [XRW-1:0] LN2_L = XRW'(LN2_Q64 >> (64 - FB));
  localparam logic signed [9:0] SOFF = 10'(62 - FB);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ISSUE = 4'd1;
  localparam logic [3:0] ST_MULW  = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_XRED  = 4'd4;
  localparam logic [3:0] ST_XFIX  = 4'd5;
  localparam logic [3:0] ST_XMUL  = 4'd6;
  localparam logic [3:0] ST_XDIV  = 4'd7;
  localparam logic [3:0] ST_XFIN  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  function automatic word_t clampx(input logic signed [64:0] v);
    word_t r;
    if (v > WMAX65) r = WMAX;
    else if (v < WMIN65) r = WMIN;
    else r = v[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] magw(input word_t v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  logic [46:0] s0_r, v0_r, kappa_r, theta_r, sigma_r;
  logic [33:0] r_r, rho_r;
  logic [32:0] dt_r;

  logic [3:0]  state_r, state_nxt;
  logic [4:0]  pc_r, pc_nxt;
  word_t       price_r, price_nxt, pv_r, pv_nxt, z1_r, z1_nxt, z2_r, z2_nxt;
  word_t       t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  word_t       t3_r, t3_nxt, t4_r, t4_nxt, t5_r, t5_nxt;
  logic        last_r, last_nxt, flag_r, flag_nxt, neg_r, neg_nxt;
  logic        otv_r, otv_nxt, oflow_r, oflow_nxt;
  logic [46:0] oprice_r, oprice_nxt;
  logic [47:0] ovar_r, ovar_nxt;
  logic [RWE-1:0] rad_r, rad_nxt;
  logic [NQ+1:0]  rem_r, rem_nxt;
  logic [NQ-1:0]  root_r, root_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt;
  logic [XRW-1:0] xrem_r, xrem_nxt;
  logic [6:0]  q_r, q_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic        xneg_r, xneg_nxt;
  logic [5:0]  s_r, s_nxt;
  logic [63:0] r62_r, r62_nxt, sum_r, sum_nxt, dq_r, dq_nxt;
  logic [5:0]  drem_r, drem_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [4:0]  n_r, n_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  hpes_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  word_t srcv [NSRC];
  word_t vp, opa, opb;
  uop_t  uop;

  assign vp  = pv_r[W-1] ? '0 : pv_r;
  assign uop = prog(pc_r);

  assign srcv[SRC_Z1]    = z1_r;
  assign srcv[SRC_Z2]    = z2_r;
  assign srcv[SRC_R]     = clampx(65'(signed'(r_r)));
  assign srcv[SRC_KAPPA] = clampx(65'(kappa_r));
  assign srcv[SRC_THETA] = clampx(65'(theta_r));
  assign srcv[SRC_SIGMA] = clampx(65'(sigma_r));
  assign srcv[SRC_RHO]   = clampx(65'(signed'(rho_r)));
  assign srcv[SRC_DT]    = clampx(65'(dt_r));
  assign srcv[SRC_ONE]   = ONE_W;
  assign srcv[SRC_VP]    = vp;
  assign srcv[SRC_VPH]   = vp >>> 1;
  assign srcv[SRC_PRICE] = price_r;
  assign srcv[SRC_PV]    = pv_r;
  assign srcv[SRC_T0]    = t0_r;
  assign srcv[SRC_T1]    = t1_r;
  assign srcv[SRC_T2]    = t2_r;
  assign srcv[SRC_T3]    = t3_r;
  assign srcv[SRC_T4]    = t4_r;
  assign srcv[SRC_T5]    = t5_r;

  assign opa = srcv[uop.a];
  assign opb = srcv[uop.b];

  logic [W:0]     addw, subw;
  logic [127:0]   prodsh, plim, pq;
  logic           fm_sat;
  logic [W-1:0]   fm_q;
  logic [NQ+1:0]  rem_t, trial;
  logic [63:0]    ex_v;
  logic [CW-1:0]  xc;

  assign addw   = {opa[W-1], opa} + {opb[W-1], opb};
  assign subw   = {opa[W-1], opa} - {opb[W-1], opb};
  assign prodsh = mrsp.prod >> FB;
  assign plim   = neg_r ? LIMN : LIMP;
  assign fm_sat = prodsh > plim;
  assign pq     = fm_sat ? plim : prodsh;
  assign fm_q   = neg_r ? (~pq[W-1:0] + W'(1)) : pq[W-1:0];
  assign rem_t  = {rem_r[NQ-1:0], rad_r[RWE-1:RWE-2]};
  assign trial  = {root_r, 2'b01};
  assign ex_v   = sum_r >> s_r;
  assign xc     = CW'(opa);

  logic           wb_en, sat_ev;
  word_t          wb_val;

  always_comb begin
    logic [63:0]    dq_t;
    logic [5:0]     dr_t;
    logic [9:0]     kq;
    logic signed [9:0] k, s;
    logic [XRW-1:0] f, lsh;
    logic [NQ-1:0]  root_t;

    state_nxt  = state_r;
    pc_nxt     = pc_r;
    price_nxt  = price_r;
    pv_nxt     = pv_r;
    z1_nxt     = z1_r;
    z2_nxt     = z2_r;
    t0_nxt     = t0_r;
    t1_nxt     = t1_r;
    t2_nxt     = t2_r;
    t3_nxt     = t3_r;
    t4_nxt     = t4_r;
    t5_nxt     = t5_r;
    last_nxt   = last_r;
    flag_nxt   = flag_r;
    neg_nxt    = neg_r;
    otv_nxt    = otv_r;
    oflow_nxt  = oflow_r;
    oprice_nxt = oprice_r;
    ovar_nxt   = ovar_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    scnt_nxt   = scnt_r;
    xrem_nxt   = xrem_r;
    q_nxt      = q_r;
    bcnt_nxt   = bcnt_r;
    xneg_nxt   = xneg_r;
    s_nxt      = s_r;
    r62_nxt    = r62_r;
    sum_nxt    = sum_r;
    dq_nxt     = dq_r;
    drem_nxt   = drem_r;
    dcnt_nxt   = dcnt_r;
    n_nxt      = n_r;
    wb_en      = 1'b0;
    wb_val     = '0;
    sat_ev     = 1'b0;
    mreq       = '0;

    dq_t = dq_r;
    dr_t = drem_r;
    for (int j = 0; j < 4; j++) begin
      dr_t = {dr_t[4:0], dq_t[63]};
      dq_t = {dq_t[62:0], 1'b0};
      if (dr_t >= {1'b0, n_r}) begin
        dr_t    = dr_t - {1'b0, n_r};
        dq_t[0] = 1'b1;
      end
    end

    kq = {3'b000, q_r};
    if (!xneg_r) begin
      k = kq;
      f = xrem_r;
    end else if (xrem_r != '0) begin
      k = -(kq + 10'd1);
      f = LN2_L - xrem_r;
    end else begin
      k = -kq;
      f = '0;
    end
    s   = SOFF - k;
    lsh = LN2_L << bcnt_r;

    if (rem_t >= trial) root_t = {root_r[NQ-2:0], 1'b1};
    else root_t = {root_r[NQ-2:0], 1'b0};

    if (otv_r && out_tready) otv_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          z1_nxt   = clampx(65'(signed'(in_tdata[35:0])));
          z2_nxt   = clampx(65'(signed'(in_tdata[71:36])));
          last_nxt = in_tlast;
          if (in_tuser) begin
            price_nxt = clampx(65'(s0_r));
            pv_nxt    = clampx(65'(v0_r));
            flag_nxt  = 1'b0;
          end
          pc_nxt    = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (uop.kind)
          K_ADD: begin
            wb_en  = 1'b1;
            sat_ev = addw[W] != addw[W-1];
            wb_val = sat_ev ? (addw[W] ? WMIN : WMAX) : addw[W-1:0];
          end
          K_SUB: begin
            wb_en  = 1'b1;
            sat_ev = subw[W] != subw[W-1];
            wb_val = sat_ev ? (subw[W] ? WMIN : WMAX) : subw[W-1:0];
          end
          K_MUL: begin
            mreq.start = 1'b1;
            mreq.a     = 64'(magw(opa));
            mreq.b     = 64'(magw(opb));
            neg_nxt    = opa[W-1] ^ opb[W-1];
            state_nxt  = ST_MULW;
          end
          K_SQRT: begin
            rad_nxt   = RWE'({(opa[W-1] ? {W{1'b0}} : opa), {FB{1'b0}}});
            rem_nxt   = '0;
            root_nxt  = '0;
            scnt_nxt  = '0;
            state_nxt = ST_SQRT;
          end
          K_EXP: begin
            if ($signed(xc) < -XLIM) begin
              wb_en  = 1'b1;
              wb_val = '0;
            end else if ($signed(xc) > XLIM) begin
              wb_en  = 1'b1;
              wb_val = WMAX;
              sat_ev = 1'b1;
            end else begin
              xneg_nxt  = opa[W-1];
              xrem_nxt  = XRW'(magw(opa));
              q_nxt     = '0;
              bcnt_nxt  = 3'd6;
              state_nxt = ST_XRED;
            end
          end
          default: begin
            wb_en  = 1'b1;
            wb_val = opa;
          end
        endcase
      end
      ST_MULW: begin
        if (mrsp.done) begin
          wb_en  = 1'b1;
          wb_val = fm_q;
          sat_ev = fm_sat;
        end
      end
      ST_SQRT: begin
        rad_nxt  = rad_r << 2;
        rem_nxt  = (rem_t >= trial) ? (rem_t - trial) : rem_t;
        root_nxt = root_t;
        scnt_nxt = scnt_r + SCW'(1);
        if (scnt_r == SCW'(NQ - 1)) begin
          wb_en  = 1'b1;
          sat_ev = 64'(root_t) > WMAX64;
          wb_val = sat_ev ? WMAX : root_t[W-1:0];
        end
      end
      ST_XRED: begin
        if (xrem_r >= lsh) begin
          xrem_nxt     = xrem_r - lsh;
          q_nxt[bcnt_r] = 1'b1;
        end
        if (bcnt_r == 3'd0) state_nxt = ST_XFIX;
        else bcnt_nxt = bcnt_r - 3'd1;
      end
      ST_XFIX: begin
        if (s[9]) begin
          wb_en  = 1'b1;
          wb_val = WMAX;
          sat_ev = 1'b1;
        end else if (s >= 10'sd64) begin
          wb_en  = 1'b1;
          wb_val = '0;
        end else begin
          r62_nxt    = 64'(f) << (62 - FB);
          sum_nxt    = ONE_Q62;
          n_nxt      = 5'd1;
          s_nxt      = s[5:0];
          mreq.start = 1'b1;
          mreq.a     = ONE_Q62;
          mreq.b     = 64'(f) << (62 - FB);
          state_nxt  = ST_XMUL;
        end
      end
      ST_XMUL: begin
        if (mrsp.done) begin
          dq_nxt    = mrsp.prod[125:62];
          drem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_XDIV;
        end
      end
      ST_XDIV: begin
        dq_nxt   = dq_t;
        drem_nxt = dr_t;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          sum_nxt = sum_r + dq_t;
          if (n_r == TAYLOR_N) begin
            state_nxt = ST_XFIN;
          end else begin
            n_nxt      = n_r + 5'd1;
            mreq.start = 1'b1;
            mreq.a     = dq_t;
            mreq.b     = r62_r;
            state_nxt  = ST_XMUL;
          end
        end
      end
      ST_XFIN: begin
        wb_en  = 1'b1;
        sat_ev = ex_v > WMAX64;
        wb_val = sat_ev ? WMAX : ex_v[W-1:0];
      end
      ST_DONE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!otv_r || out_tready) begin
          otv_nxt    = 1'b1;
          oprice_nxt = price_r[W-1] ? '0 : 47'(64'(price_r));
          ovar_nxt   = 48'(64'(pv_r));
          oflow_nxt  = flag_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (wb_en) begin
      case (uop.dst)
        D_T0:    t0_nxt    = wb_val;
        D_T1:    t1_nxt    = wb_val;
        D_T2:    t2_nxt    = wb_val;
        D_T3:    t3_nxt    = wb_val;
        D_T4:    t4_nxt    = wb_val;
        D_T5:    t5_nxt    = wb_val;
        D_PRICE: price_nxt = wb_val;
        D_PV:    pv_nxt    = wb_val;
        default: t4_nxt    = wb_val;
      endcase
      if (pc_r == LAST_PC) begin
        state_nxt = ST_DONE;
      end else begin
        pc_nxt    = pc_r + 5'd1;
        state_nxt = ST_ISSUE;
      end
    end

    if (sat_ev) flag_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      otv_r   <= 1'b0;
      flag_r  <= 1'b0;
      price_r <= '0;
      pv_r    <= '0;
      s0_r    <= 47'd429496729600;
      v0_r    <= 47'd171798692;
      r_r     <= '0;
      kappa_r <= 47'd8589934592;
      theta_r <= 47'd171798692;
      sigma_r <= 47'd1288490189;
      rho_r   <= '0;
      dt_r    <= 33'd17043521;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      otv_r   <= otv_nxt;
      flag_r  <= flag_nxt;
      price_r <= price_nxt;
      pv_r    <= pv_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_S0:    s0_r    <= cfg_wdata;
          REG_V0:    v0_r    <= cfg_wdata;
          REG_R:     r_r     <= cfg_wdata[33:0];
          REG_KAPPA: kappa_r <= cfg_wdata;
          REG_THETA: theta_r <= cfg_wdata;
          REG_SIGMA: sigma_r <= cfg_wdata;
          REG_RHO:   rho_r   <= cfg_wdata[33:0];
          REG_DT:    dt_r    <= cfg_wdata[32:0];
          default:   dt_r    <= dt_r;
        endcase
      end
    end
    z1_r     <= z1_nxt;
    z2_r     <= z2_nxt;
    t0_r     <= t0_nxt;
    t1_r     <= t1_nxt;
    t2_r     <= t2_nxt;
    t3_r     <= t3_nxt;
    t4_r     <= t4_nxt;
    t5_r     <= t5_nxt;
    last_r   <= last_nxt;
    neg_r    <= neg_nxt;
    oflow_r  <= oflow_nxt;
    oprice_r <= oprice_nxt;
    ovar_r   <= ovar_nxt;
    rad_r    <= rad_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    scnt_r   <= scnt_nxt;
    xrem_r   <= xrem_nxt;
    q_r      <= q_nxt;
    bcnt_r   <= bcnt_nxt;
    xneg_r   <= xneg_nxt;
    s_r      <= s_nxt;
    r62_r    <= r62_nxt;
    sum_r    <= sum_nxt;
    dq_r     <= dq_nxt;
    drem_r   <= drem_nxt;
    dcnt_r   <= dcnt_nxt;
    n_r      <= n_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = otv_r;
  assign out_tdata  = {1'b0, ovar_r, oprice_r};
  assign out_tuser  = oflow_r;

endmodule

// ===== test/tb.sv =====
module tb;
  import hpes_pkg::*;

  localparam longint WMAX = (longint'(1) <<< 47) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint ONE_Q = longint'(1) <<< 32;
  localparam logic [35:0] Z_ONE = 36'h100000000;
  localparam logic [35:0] Z_MAX = 36'h7FFFFFFFF;
  localparam logic [35:0] Z_MIN = 36'h800000000;
  localparam int IDLE_CYCLES = 800;

  typedef struct {
    logic [35:0] z1;
    logic [35:0] z2;
    bit          first;
    bit          last;
  } shock_row_t;

  typedef struct {
    logic [46:0] price;
    logic [47:0] variance;
    bit          ovf;
  } path_end_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [46:0] cfg_wdata;

  heston_path_euler_step dut (.*);

  int          reg_width [8] = '{47, 47, 34, 47, 47, 47, 34, 33};
  bit          reg_sign [8] = '{0, 0, 1, 0, 0, 0, 1, 0};
  logic [46:0] model_regs [8] = '{47'd429496729600, 47'd171798692, 47'd0,
                                  47'd8589934592, 47'd171798692, 47'd1288490189,
                                  47'd0, 47'd17043521};
  longint      model_price;
  longint      model_var;
  bit          model_sat;
  bit          sat_hit;

  path_end_t   pending_ends[$];
  int          errors;
  int          n_accepted;
  bit          long_hold_done;

  shock_row_t  directed_rows [13] = '{
    '{Z_ONE, -Z_ONE, 0, 1},
    '{36'd0, 36'd0, 1, 1},
    '{Z_MAX, Z_MAX, 1, 1},
    '{Z_MIN, Z_MIN, 1, 1},
    '{Z_MAX, Z_MIN, 1, 0},
    '{Z_ONE, Z_ONE, 0, 1},
    '{Z_MIN, Z_MAX, 1, 1},
    '{36'h200000000, -Z_ONE, 1, 0},
    '{-Z_ONE, Z_ONE, 0, 0},
    '{36'h080000000, Z_ONE, 0, 1},
    '{36'h0FFFFFFFF, 36'hF00000001, 1, 1},
    '{36'd0, 36'd0, 0, 0},
    '{36'd0, 36'd0, 0, 1}
  };

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint sat_word(logic [63:0] q);
    if (q > 64'(WMAX)) begin
      sat_hit = 1;
      q = 64'(WMAX);
    end
    return longint'(q);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  q;
    logic [63:0]  lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    q = p[95:32];
    lim = neg ? 64'(WMAX) + 64'd1 : 64'(WMAX);
    if (p[127:96] != 0 || q > lim) begin
      sat_hit = 1;
      q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint q_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > WMAX) begin
      sat_hit = 1;
      return WMAX;
    end
    if (s < WMIN) begin
      sat_hit = 1;
      return WMIN;
    end
    return s;
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return q_add(a, -b);
  endfunction

  function automatic longint q_sqrt(longint x);
    logic [63:0]  ux;
    logic [127:0] target;
    logic [63:0]  root;
    logic [63:0]  cand;
    ux = x > 0 ? 64'(x) : 64'd0;
    target = {32'd0, ux, 32'd0};
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= target) root = cand;
    end
    return sat_word(root);
  endfunction

  function automatic longint q_exp(longint x);
    logic [63:0]  ln2;
    logic [63:0]  r62;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    longint       k;
    longint       s;
    ln2 = LN2_Q64 >> 32;
    if (x < -(longint'(64) <<< 32)) return 0;
    if (x > (longint'(64) <<< 32)) begin
      sat_hit = 1;
      return WMAX;
    end
    if (x >= 0) k = longint'(64'(x) / ln2);
    else k = -longint'((magnitude(x) + ln2 - 64'd1) / ln2);
    r62 = 64'(x - k * longint'(ln2)) << 30;
    term = 64'd1 << 62;
    sum = term;
    for (int n = 1; n <= 24; n++) begin
      p = {64'd0, term} * {64'd0, r62};
      term = p[125:62] / 64'(n);
      sum = sum + term;
    end
    s = 30 - k;
    if (s < 0) begin
      sat_hit = 1;
      return WMAX;
    end
    if (s >= 64) return 0;
    return sat_word(sum >> s);
  endfunction

  function automatic longint reg_value(int i);
    logic [63:0] v;
    v = 64'(model_regs[i]) & ((64'd1 << reg_width[i]) - 64'd1);
    if (reg_sign[i] && v[reg_width[i]-1]) return longint'(v) - (longint'(1) <<< reg_width[i]);
    return longint'(v);
  endfunction

  function automatic bit euler_step(logic [35:0] z1_raw, logic [35:0] z2_raw, bit first,
                                    bit last, output path_end_t res);
    longint z1, z2, r, kappa, theta, sigma, rho, dt;
    longint vp, sqv, sqdt, d, zv, arg, dv, ds;
    z1 = longint'($signed(z1_raw));
    z2 = longint'($signed(z2_raw));
    r = reg_value(REG_R);
    kappa = reg_value(REG_KAPPA);
    theta = reg_value(REG_THETA);
    sigma = reg_value(REG_SIGMA);
    rho = reg_value(REG_RHO);
    dt = reg_value(REG_DT);
    if (first) begin
      model_price = reg_value(REG_S0);
      model_var = reg_value(REG_V0);
      model_sat = 0;
    end
    sat_hit = 0;
    sqdt = q_sqrt(dt);
    d = q_sub(ONE_Q, q_mul(rho, rho));
    if (d < 0) d = 0;
    zv = q_add(q_mul(rho, z1), q_mul(q_sqrt(d), z2));
    vp = model_var > 0 ? model_var : 0;
    sqv = q_sqrt(vp);
    arg = q_add(q_mul(q_sub(r, vp >>> 1), dt), q_mul(q_mul(sqv, sqdt), z1));
    model_price = q_mul(model_price, q_exp(arg));
    dv = q_mul(q_mul(kappa, q_sub(theta, vp)), dt);
    ds = q_mul(q_mul(q_mul(sigma, sqv), sqdt), zv);
    model_var = q_add(q_add(model_var, dv), ds);
    if (sat_hit) model_sat = 1;
    res.price = model_price < 0 ? 47'd0 : 47'(model_price);
    res.variance = 48'(model_var);
    res.ovf = model_sat;
    return last;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    path_end_t got;
    path_end_t want;
    path_end_t res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.price = out_tdata[46:0];
        got.variance = out_tdata[94:47];
        got.ovf = out_tuser;
        if (pending_ends.size() == 0) begin
          errors++;
          $display("%0t: unexpected result price=%h var=%h ovf=%b", $time,
                   got.price, got.variance, got.ovf);
        end else begin
          want = pending_ends.pop_front();
          if (got.price !== want.price) begin
            errors++;
            $display("%0t: price exp %h got %h", $time, want.price, got.price);
          end
          if (got.variance !== want.variance) begin
            errors++;
            $display("%0t: variance exp %h got %h", $time, want.variance, got.variance);
          end
          if (got.ovf !== want.ovf) begin
            errors++;
            $display("%0t: overflow exp %b got %b", $time, want.ovf, got.ovf);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_accepted++;
        if (euler_step(in_tdata[35:0], in_tdata[71:36], in_tuser, in_tlast, res))
          pending_ends.push_back(res);
      end
    end
  end

  initial begin
    int pick;
    int len;
    out_tready = 0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && n_accepted >= 150) begin
        long_hold_done = 1;
        out_tready <= 0;
        repeat (5000) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1;
          len = $urandom_range(1, 20);
        end else if (pick < 95) begin
          out_tready <= 0;
          len = $urandom_range(1, 4);
        end else begin
          out_tready <= 0;
          len = $urandom_range(20, 200);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic send(logic [35:0] z1, logic [35:0] z2, bit first, bit last);
    int pick;
    int gap;
    in_tvalid <= 1;
    in_tdata <= {z2, z1};
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    pick = $urandom_range(0, 99);
    gap = pick < 50 ? 0 : (pick < 92 ? $urandom_range(1, 3) : $urandom_range(20, 100));
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_ends.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [46:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      model_regs[i] = vals[i] & 47'((64'd1 << reg_width[i]) - 64'd1);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [35:0] rand_shock();
    if ($urandom_range(0, 99) < 85)
      return 36'((longint'($urandom_range(0, 8000)) - 4000) * (ONE_Q / 1000));
    return 36'({$urandom, $urandom});
  endfunction

  function automatic logic [46:0] q_frac(int lo, int hi, int scale);
    return 47'((longint'($urandom_range(lo, hi)) * ONE_Q) / scale);
  endfunction

  initial begin
    logic [46:0] vals [8];
    int remaining;
    int path_len;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    in_tlast = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    n_accepted = 0;
    long_hold_done = 0;
    model_price = 0;
    model_var = 0;
    model_sat = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed_rows[i])
      send(directed_rows[i].z1, directed_rows[i].z2, directed_rows[i].first,
           directed_rows[i].last);
    drain();

    vals[REG_S0] = 47'h7FFFFFFFFFFF;
    vals[REG_V0] = 47'h7FFFFFFFFFFF;
    vals[REG_R] = 47'h100000000;
    vals[REG_KAPPA] = 47'h7FFFFFFFFFFF;
    vals[REG_THETA] = 47'h7FFFFFFFFFFF;
    vals[REG_SIGMA] = 47'h7FFFFFFFFFFF;
    vals[REG_RHO] = 47'h1FFFFFFFF;
    vals[REG_DT] = 47'h100000000;
    write_regs(vals);
    for (int i = 1; i <= 4; i++)
      send(directed_rows[i].z1, directed_rows[i].z2, directed_rows[i].first, 1);
    drain();

    vals[REG_S0] = 47'd1;
    vals[REG_V0] = 47'd0;
    vals[REG_R] = 47'h200000000;
    vals[REG_KAPPA] = 47'd0;
    vals[REG_THETA] = 47'd0;
    vals[REG_SIGMA] = 47'd0;
    vals[REG_RHO] = 47'h200000000;
    vals[REG_DT] = 47'd1;
    write_regs(vals);
    for (int i = 1; i <= 4; i++)
      send(directed_rows[i].z1, directed_rows[i].z2, directed_rows[i].first, 1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      vals[REG_S0] = q_frac(1, 500, 1);
      vals[REG_V0] = q_frac(0, 300, 1000);
      vals[REG_R] = 47'(q_frac(0, 200, 1000) - 47'(ONE_Q / 10));
      vals[REG_KAPPA] = q_frac(0, 80, 10);
      vals[REG_THETA] = q_frac(0, 200, 1000);
      vals[REG_SIGMA] = q_frac(0, 150, 100);
      vals[REG_RHO] = phase == 0 ? 47'h3FFFFFFFF & 47'(-ONE_Q) :
                      47'(q_frac(0, 200, 100) - 47'(ONE_Q));
      vals[REG_DT] = q_frac(1, 83, 1000);
      write_regs(vals);
      remaining = 106;
      while (remaining > 0) begin
        if (phase == 2 && remaining == 50) drain();
        if ($urandom_range(0, 9) == 0) begin
          send(rand_shock(), rand_shock(), $urandom_range(0, 1), $urandom_range(0, 1));
          remaining--;
        end else begin
          path_len = $urandom_range(1, 12);
          for (int s = 0; s < path_len; s++) begin
            send(rand_shock(), rand_shock(), s == 0, s == path_len - 1);
            remaining--;
          end
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
